@@ hw/rtl/rgbhsv_pkg.sv @@
// Shared widths, constants and command types of the RGB to HSV converter.
package rgbhsv_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 8;
   localparam int HUE_BITS      = HUE_FRAC_BITS + 3;

   // Quotient bits per divide: hue needs HUE_FRAC_BITS+1, saturation CHANNEL_BITS.
   localparam int QUOT_BITS = (HUE_FRAC_BITS + 1 > CHANNEL_BITS) ?
                              HUE_FRAC_BITS + 1 : CHANNEL_BITS;
   localparam int DIVN_BITS = CHANNEL_BITS + QUOT_BITS;
   localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

   localparam logic [HUE_BITS-1:0] HUE_TWO_SIXTHS  = HUE_BITS'(2 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] HUE_FOUR_SIXTHS = HUE_BITS'(4 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] HUE_FULL_TURN   = HUE_BITS'(6 << HUE_FRAC_BITS);

   // Sector of the largest channel.
   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0]     hue_type;

   typedef struct packed {
      logic load;    // capture a new pixel and seed both dividers
      logic step;    // advance both dividers by one quotient bit
      logic commit;  // fold the quotients into the held result
   } cmd_type;

endpackage

@@ hw/rtl/rgbhsv_if.sv @@
// Valid/ready channel interfaces for pixels in and HSV results out.
interface rgbhsv_req_if;
   import rgbhsv_pkg::*;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_rsp_if;
   import rgbhsv_pkg::*;
   logic     valid;
   logic     ready;
   hue_type  hue;
   chan_type saturation;
   chan_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

@@ hw/rtl/rgbhsv_ctrl.sv @@
// Sequencer of the converter: accepts a beat, runs the dividers, hands off the result.
module rgbhsv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output rgbhsv_pkg::cmd_type cmd
);
   import rgbhsv_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold the quotients until the output slot frees up
            if (!out_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = cmd.commit | (out_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ hw/rtl/rgbhsv_dp.sv @@
// Datapath: max/min, two restoring dividers and the held hue/saturation result.
module rgbhsv_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbhsv_pkg::cmd_type  cmd,
   input  rgbhsv_pkg::chan_type red,
   input  rgbhsv_pkg::chan_type green,
   input  rgbhsv_pkg::chan_type blue,
   output rgbhsv_pkg::hue_type  hue,
   output rgbhsv_pkg::chan_type saturation,
   output rgbhsv_pkg::chan_type brightness
);
   import rgbhsv_pkg::*;

   typedef struct packed {
      chan_type               rem;
      logic [QUOT_BITS-1:0]   num;
   } lane_type;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic lane_type div_step(lane_type cur, chan_type den);
      logic [CHANNEL_BITS:0] trial;
      lane_type              nxt;
      trial = {cur.rem, cur.num[QUOT_BITS-1]};
      nxt.num = {cur.num[QUOT_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         trial      = trial - {1'b0, den};
         nxt.num[0] = 1'b1;
      end
      nxt.rem = trial[CHANNEL_BITS-1:0];
      return nxt;
   endfunction

   // pixel working registers
   chan_type   mx_ff, diff_ff;
   logic [1:0] sector_ff;
   logic       neg_ff;
   lane_type   sat_ff, sat_in, hdiv_ff, hdiv_in;

   // result registers; hue and saturation are also the held state
   hue_type    held_hue_ff, held_hue_in;
   chan_type   held_sat_ff, held_sat_in;
   chan_type   bright_ff;

   // load-side combinational values
   chan_type               mx_c, mn_c, d_c, pos_c, sub_c, mag_c;
   logic [1:0]             sector_c;
   logic                   neg_c;
   logic [DIVN_BITS-1:0]   sat_num_c, hue_num_c;

   // commit-side hue assembly
   hue_type                q_c, term_c, base_c, hue_c;

   always_comb begin
      mx_c = (red > green) ? red : green;
      mn_c = (red < green) ? red : green;
      if (blue > mx_c) mx_c = blue;
      if (blue < mn_c) mn_c = blue;
      d_c = mx_c - mn_c;

      if (mx_c == red) begin
         sector_c = SECTOR_RED;
         pos_c    = green;
         sub_c    = blue;
      end else if (mx_c == green) begin
         sector_c = SECTOR_GREEN;
         pos_c    = blue;
         sub_c    = red;
      end else begin
         sector_c = SECTOR_BLUE;
         pos_c    = red;
         sub_c    = green;
      end
      neg_c = pos_c < sub_c;
      mag_c = neg_c ? (sub_c - pos_c) : (pos_c - sub_c);

      // full-scale times difference as shift minus one
      sat_num_c = (DIVN_BITS'(d_c) << CHANNEL_BITS) - DIVN_BITS'(d_c);
      hue_num_c = DIVN_BITS'(mag_c) << HUE_FRAC_BITS;
   end

   always_comb begin
      sat_in  = sat_ff;
      hdiv_in = hdiv_ff;
      if (cmd.load) begin
         sat_in.rem  = sat_num_c[DIVN_BITS-1:QUOT_BITS];
         sat_in.num  = sat_num_c[QUOT_BITS-1:0];
         hdiv_in.rem = hue_num_c[DIVN_BITS-1:QUOT_BITS];
         hdiv_in.num = hue_num_c[QUOT_BITS-1:0];
      end else if (cmd.step) begin
         sat_in  = div_step(sat_ff, mx_ff);
         hdiv_in = div_step(hdiv_ff, diff_ff);
      end
   end

   always_comb begin
      q_c    = HUE_BITS'(hdiv_ff.num);
      term_c = neg_ff ? (HUE_BITS'(0) - q_c) : q_c;
      case (sector_ff)
         SECTOR_RED:   base_c = (neg_ff && (q_c != '0)) ? HUE_FULL_TURN : '0;
         SECTOR_GREEN: base_c = HUE_TWO_SIXTHS;
         SECTOR_BLUE:  base_c = HUE_FOUR_SIXTHS;
         default:      base_c = '0;
      endcase
      hue_c = base_c + term_c;

      held_hue_in = held_hue_ff;
      held_sat_in = held_sat_ff;
      if (cmd.commit && (mx_ff != '0)) begin
         held_sat_in = sat_ff.num[CHANNEL_BITS-1:0];
         if (diff_ff != '0) begin
            held_hue_in = hue_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      sat_ff  <= sat_in;
      hdiv_ff <= hdiv_in;
      if (cmd.load) begin
         mx_ff     <= mx_c;
         diff_ff   <= d_c;
         sector_ff <= sector_c;
         neg_ff    <= neg_c;
      end
      if (cmd.commit) begin
         bright_ff <= mx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_hue_ff <= '0;
         held_sat_ff <= '0;
      end else begin
         held_hue_ff <= held_hue_in;
         held_sat_ff <= held_sat_in;
      end
   end

   assign hue        = held_hue_ff;
   assign saturation = held_sat_ff;
   assign brightness = bright_ff;

endmodule

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// Top level of the RGB to HSV converter: sequencer plus datapath.
//
// Usage:
//   req_chan carries one pixel per beat (red, green, blue, 255 = full scale).
//   rsp_chan returns one beat per pixel: hue in sixths of a turn with 8
//   fraction bits (0..1535), saturation = floor(255*(max-min)/max) and
//   brightness = largest channel.
//   A black pixel repeats the previous hue and saturation; a gray pixel
//   gives saturation 0 and repeats the previous hue.
// Timing:
//   Saturation and hue are divided side by side on two restoring dividers,
//   one quotient bit per cycle, 9 bits each. An accepted pixel is loaded,
//   runs its divide steps and is committed into the result registers,
//   which puts it on rsp_chan. The sequencer then returns to idle to take
//   the next pixel, so none is taken before the last one is committed.
//   The result sits in its own register, so the next pixel is taken and
//   divided while a result still waits; only the commit waits on rsp ready.
// Reset:
//   Synchronous, active high. Clears the sequencer, drops rsp valid and
//   zeroes the held hue and saturation.
// Stall:
//   While rsp ready is low the result beat holds; the pixel behind it
//   finishes its divides and holds before the commit, and req ready stays low.
module rgb_to_hsv_converter (
   input  logic clock,
   input  logic reset,
   rgbhsv_req_if.sink   req_chan,
   rgbhsv_rsp_if.source rsp_chan
);
   import rgbhsv_pkg::*;

   cmd_type cmd;

   rgbhsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   rgbhsv_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .red        (req_chan.red),
      .green      (req_chan.green),
      .blue       (req_chan.blue),
      .hue        (rsp_chan.hue),
      .saturation (rsp_chan.saturation),
      .brightness (rsp_chan.brightness)
   );

endmodule

@@ hw/rtl/rgbhsv_checker.sv @@
// Port-level assertions for the converter, bound to the top level.
module rgbhsv_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rgbhsv_pkg::hue_type  rsp_hue,
   input rgbhsv_pkg::chan_type rsp_saturation,
   input rgbhsv_pkg::chan_type rsp_brightness
);
   import rgbhsv_pkg::*;

   // a stalled result beat holds valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue) &&
         $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled result beat changed");

   // one pixel in work: no new beat right after an accepted one
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a pixel is in work");

   // hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_FULL_TURN)
      else $error("hue out of range");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hue        (rsp_chan.hue),
   .rsp_saturation (rsp_chan.saturation),
   .rsp_brightness (rsp_chan.brightness)
);
